// ===== rtl/bbd_pkg.sv =====
// ---------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants for the button bank debouncer.
// ---------------------------------------------------------------------------
package bbd_pkg;

	localparam int NUM_BUTTONS = 8;
	// lanes past the 8-bit pin/mask fields still need padded vectors
	localparam int WIDE_W      = (NUM_BUTTONS > 8) ? NUM_BUTTONS : 8;
	localparam int CNT_W       = $clog2(NUM_BUTTONS + 1);

	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_EDGE     = 2'd1,
		ACT_PRESSES  = 2'd2,
		ACT_RELEASES = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_RISING  = 2'd0,
		MODE_FALLING = 2'd1,
		MODE_CHANGE  = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_BUTTON_COUNT  = 2'd0,
		REG_SETTLE_TICKS  = 2'd1,
		REG_TRIGGER_MODES = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] pin_levels;
		logic [2:0] button_index;
	} in_item_t;

	typedef struct packed {
		logic [3:0] event_count;
		logic [7:0] event_mask;
	} out_item_t;

	// per-lane request for one accepted item
	typedef struct packed {
		logic    take;
		action_t action;
		logic    pin;
		logic    en;
		logic    edge_sel;
	} lane_req_t;

endpackage

// ===== rtl/bbd_lane.sv =====
// ---------------------------------------------------------------------------
// bbd_lane
// Settle counter, stable level and latched press/release flags for one button.
// ---------------------------------------------------------------------------
module bbd_lane
	import bbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lane_req_t req,
	input  logic [7:0] settle_ticks,
	input  mode_t     mode,
	output logic      hit
);

	logic       idle_q;
	logic [7:0] cnt_q;
	logic       stable_q;
	logic       press_q;
	logic       release_q;

	logic differs;
	logic qual_press;
	logic qual_release;

	assign differs      = (stable_q != req.pin);
	assign qual_press   = (mode == MODE_CHANGE) || (mode == MODE_FALLING);
	assign qual_release = (mode == MODE_CHANGE) || (mode == MODE_RISING);

	always_comb begin
		hit = 1'b0;
		if (req.en) begin
			unique case (req.action)
				ACT_PRESSES:  hit = press_q && qual_press;
				ACT_RELEASES: hit = release_q && qual_release;
				default:      hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q    <= 1'b1;
			cnt_q     <= '0;
			stable_q  <= 1'b1;
			press_q   <= 1'b0;
			release_q <= 1'b0;
		end else if (req.take && req.en) begin
			unique case (req.action)
				ACT_TICK: begin
					if (idle_q) begin
						if (differs) begin
							idle_q <= 1'b0;
							cnt_q  <= settle_ticks;
						end
					end else if (cnt_q != '0) begin
						cnt_q <= cnt_q - 8'd1;
					end else begin
						idle_q <= 1'b1;
						if (differs) begin
							// high to low is a press on a pulled-up button
							if (stable_q) press_q <= 1'b1;
							else release_q <= 1'b1;
							stable_q <= req.pin;
						end
					end
				end
				ACT_EDGE: begin
					if (req.edge_sel && idle_q && differs) begin
						idle_q <= 1'b0;
						cnt_q  <= settle_ticks;
					end
				end
				ACT_PRESSES:  press_q   <= 1'b0;
				ACT_RELEASES: release_q <= 1'b0;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/bbd_merge.sv =====
// ---------------------------------------------------------------------------
// bbd_merge
// Combines lane hits into count and mask, and holds the result register.
// ---------------------------------------------------------------------------
module bbd_merge
	import bbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [NUM_BUTTONS-1:0] hits,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	logic [CNT_W-1:0]  cnt;
	logic [WIDE_W-1:0] hits_wide;
	logic [3:0]        cnt_sat;
	logic              valid_q;
	out_item_t         data_q;

	always_comb begin
		cnt = '0;
		for (int j = 0; j < NUM_BUTTONS; j++) begin
			cnt = cnt + CNT_W'(hits[j]);
		end
	end

	assign hits_wide = WIDE_W'(hits);
	assign cnt_sat   = (32'(cnt) > 32'd15) ? 4'hF : 4'(cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q.event_count <= cnt_sat;
			data_q.event_mask  <= hits_wide[7:0];
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/button_bank_debouncer.sv =====
// ---------------------------------------------------------------------------
// button_bank_debouncer
// Debouncer for a bank of active-low pull-up buttons with collect reporting.
// ---------------------------------------------------------------------------
// One request per clock: every button has its own lane that updates in the
// cycle a request is taken, and the merged count/mask is registered, so the
// result appears in the cycle after the request and a new request is taken each
// cycle unless the result register is full and stalled. Ticks and edge
// requests return a zero result; collects return the qualifying flags.
// Registers (APB, byte address 4*i): button_count, settle_ticks,
// trigger_modes; write them only while the block is idle.
module button_bank_debouncer
	import bbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [3:0]  button_count_q;
	logic [7:0]  settle_ticks_q;
	logic [15:0] trigger_modes_q;

	logic                   take;
	logic                   cfg_wr;
	reg_idx_t               reg_sel;
	logic [WIDE_W-1:0]      pins_wide;
	logic [NUM_BUTTONS-1:0] hits;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_count_q  <= 4'd8;
			settle_ticks_q  <= 8'd20;
			trigger_modes_q <= 16'hAAAA;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_BUTTON_COUNT:  button_count_q  <= pwdata[3:0];
				REG_SETTLE_TICKS:  settle_ticks_q  <= pwdata[7:0];
				REG_TRIGGER_MODES: trigger_modes_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BUTTON_COUNT:  prdata = DATA_W'(button_count_q);
			REG_SETTLE_TICKS:  prdata = DATA_W'(settle_ticks_q);
			REG_TRIGGER_MODES: prdata = DATA_W'(trigger_modes_q);
			default:           prdata = '0;
		endcase
	end

	// result register frees up the cycle it is taken
	assign in_stall  = out_valid && out_stall;
	assign take      = in_valid && !in_stall;
	assign pins_wide = WIDE_W'(in_data.pin_levels);

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		lane_req_t req;
		mode_t     mode;

		assign req.take     = take;
		assign req.action   = action_t'(in_data.action);
		assign req.pin      = pins_wide[i];
		assign req.en       = (32'(button_count_q) > i);
		assign req.edge_sel = (32'(in_data.button_index) == i);

		// buttons past the mode register behave as change
		if (i < 8) begin : g_mode
			assign mode = mode_t'(trigger_modes_q[2*i +: 2]);
		end else begin : g_mode_default
			assign mode = MODE_CHANGE;
		end

		bbd_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.req          (req),
			.settle_ticks (settle_ticks_q),
			.mode         (mode),
			.hit          (hits[i])
		);
	end

	bbd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.hits      (hits),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result held");

	a_quiet_actions: assert property (@(posedge clk) disable iff (!arst_n)
		take && (in_data.action == ACT_TICK || in_data.action == ACT_EDGE) |=>
		out_valid && out_data.event_count == 4'd0 && out_data.event_mask == 8'd0)
		else $error("tick or edge request gave a non-zero result");

	a_count_covers_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.event_count) >= $countones(out_data.event_mask))
		else $error("event count below number of mask bits");

endmodule
